FILE: rtl/core/lruc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package lruc_pkg;

    function automatic int floor_log2(input int value);
        int v;
        int n;
        v = value;
        n = 0;
        while (v > 1) begin
            v = v / 2;
            n = n + 1;
        end
        return n;
    endfunction

    localparam int SET_COUNT    = 16;
    localparam int WAY_COUNT    = 4;
    localparam int BLOCK_BYTES  = 64;
    localparam int ADDRESS_BITS = 32;

    localparam int OFFSET_BITS = floor_log2(BLOCK_BYTES);
    localparam int SET_BITS    = floor_log2(SET_COUNT);
    localparam int SET_ROWS    = 1 << SET_BITS;
    localparam int TAG_W       = ADDRESS_BITS - OFFSET_BITS - SET_BITS;
    localparam int WAY_W       = (WAY_COUNT > 1) ? $clog2(WAY_COUNT) : 1;

    localparam int LAT_W            = 10;
    localparam int IDLE_W           = LAT_W + 2;
    localparam int PEER_FILL_CYCLES = 2 * (BLOCK_BYTES / 4);
    localparam logic [LAT_W-1:0] LAT_RESET = LAT_W'(100);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        OP_LOAD    = 2'd0,
        OP_STORE   = 2'd1,
        OP_COMPUTE = 2'd2,
        OP_EMPTY   = 2'd3
    } t_op;

    typedef enum logic {
        BK_IDLE = 1'b0,
        BK_LOOK = 1'b1
    } t_back_state;

    typedef struct packed {
        t_op                 op;
        logic [SET_BITS-1:0] set_idx;
        logic [TAG_W-1:0]    tag;
        logic [31:0]         base_cycles;
        logic                peer;
    } t_item;

    typedef struct packed {
        logic [WAY_COUNT-1:0][TAG_W-1:0] tag;
        logic [WAY_COUNT-1:0]            dirty;
        logic [WAY_COUNT-1:0][WAY_W-1:0] rank;
    } t_row;

endpackage
`default_nettype wire

FILE: rtl/core/lruc_front.sv
`timescale 1ns / 1ps
`default_nettype none
module lruc_front import lruc_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_operation,
    input  wire logic [31:0] i_address,
    input  wire logic [31:0] i_delay_cycles,
    input  wire logic        i_peer_supplies,
    output t_item            o_item,
    output logic             o_item_valid,
    input  wire logic        i_item_pop
);

    t_item             r_q [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    t_item             n_item;
    logic              push;
    logic              pop;

    always_comb begin
        n_item.op          = t_op'(i_operation);
        n_item.set_idx     = i_address[OFFSET_BITS+SET_BITS-1:OFFSET_BITS];
        n_item.tag         = i_address[ADDRESS_BITS-1:OFFSET_BITS+SET_BITS];
        n_item.peer        = i_peer_supplies;
        n_item.base_cycles = (t_op'(i_operation) == OP_COMPUTE) ?
                             i_delay_cycles + 32'd1 : 32'd1;
    end

    assign o_in_stall   = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_item_valid = (r_count != '0);
    assign o_item       = r_q[r_rd_ptr];
    assign push         = i_in_valid && !o_in_stall;
    assign pop          = i_item_pop && o_item_valid;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= n_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/lruc_back.sv
`timescale 1ns / 1ps
`default_nettype none
module lruc_back import lruc_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_wr_en,
    input  wire logic [LAT_W-1:0] i_cfg_wr_data,
    input  wire t_item            i_item,
    input  wire logic             i_item_valid,
    output logic                  o_item_pop,
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    output logic                  o_hit,
    output logic                  o_writeback,
    output logic [31:0]           o_access_cycles,
    output logic [31:0]           o_total_cycles,
    output logic [31:0]           o_idle_total,
    output logic [31:0]           o_load_total,
    output logic [31:0]           o_store_total,
    output logic [31:0]           o_load_miss_total,
    output logic [31:0]           o_store_miss_total,
    output logic [31:0]           o_compute_total
);

    t_row                 r_mem [SET_ROWS];
    t_row                 r_rdata;
    logic [WAY_COUNT-1:0] r_valid [SET_ROWS];
    t_item                r_cur;
    t_back_state          r_state;
    t_back_state          n_state;
    logic [LAT_W-1:0]     r_latency;

    logic                 r_out_valid;
    logic                 r_hit;
    logic                 r_wb;
    logic [31:0]          r_access;
    logic [31:0]          r_cycle_count;
    logic [31:0]          r_idle_count;
    logic [31:0]          r_loads;
    logic [31:0]          r_stores;
    logic [31:0]          r_load_misses;
    logic [31:0]          r_store_misses;
    logic [31:0]          r_computes;

    logic                 rd_en;
    logic                 commit;

    logic [WAY_COUNT-1:0]            set_valid;
    logic                            set_used;
    logic [WAY_COUNT-1:0][WAY_W-1:0] rank_eff;
    logic [WAY_COUNT-1:0][WAY_W-1:0] rank_new;
    logic [WAY_COUNT-1:0]            match;
    logic [WAY_COUNT-1:0]            dirty_eff;
    logic [WAY_W-1:0]                hit_way;
    logic [WAY_W-1:0]                victim;
    logic [WAY_W-1:0]                target;
    logic [WAY_W-1:0]                old_rank;
    logic                            is_mem;
    logic                            is_store;
    logic                            hit_now;
    logic                            wb_now;
    logic [IDLE_W-1:0]               idle_now;
    logic [31:0]                     cost_now;
    t_row                            wdata;

    always_comb begin
        n_state    = r_state;
        o_item_pop = 1'b0;
        rd_en      = 1'b0;
        commit     = 1'b0;
        unique case (r_state)
            BK_IDLE: begin
                if (i_item_valid) begin
                    o_item_pop = 1'b1;
                    rd_en      = 1'b1;
                    n_state    = BK_LOOK;
                end
            end
            BK_LOOK: begin
                if (!r_out_valid || !i_out_stall) begin
                    commit  = 1'b1;
                    n_state = BK_IDLE;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    always_comb begin
        set_valid = r_valid[r_cur.set_idx];
        set_used  = |set_valid;
        is_mem    = (r_cur.op == OP_LOAD) || (r_cur.op == OP_STORE);
        is_store  = (r_cur.op == OP_STORE);
        for (int w = 0; w < WAY_COUNT; w++) begin
            rank_eff[w]  = set_used ? r_rdata.rank[w] : WAY_W'(w);
            match[w]     = set_valid[w] && (r_rdata.tag[w] == r_cur.tag);
            dirty_eff[w] = set_valid[w] && r_rdata.dirty[w];
        end
        hit_now = |match;
        hit_way = '0;
        for (int w = WAY_COUNT - 1; w >= 0; w--) begin
            if (match[w]) begin
                hit_way = WAY_W'(w);
            end
        end
        victim = '0;
        for (int w = 0; w < WAY_COUNT; w++) begin
            if (rank_eff[w] == WAY_W'(WAY_COUNT - 1)) begin
                victim = WAY_W'(w);
            end
        end
        target   = hit_now ? hit_way : victim;
        old_rank = rank_eff[target];
        for (int w = 0; w < WAY_COUNT; w++) begin
            if (WAY_W'(w) == target) begin
                rank_new[w] = '0;
            end else if (rank_eff[w] < old_rank) begin
                rank_new[w] = WAY_W'(rank_eff[w] + 1'b1);
            end else begin
                rank_new[w] = rank_eff[w];
            end
        end
        wb_now   = !hit_now && dirty_eff[victim];
        idle_now = (wb_now ? IDLE_W'(r_latency) : '0) +
                   (r_cur.peer ? IDLE_W'(PEER_FILL_CYCLES) : IDLE_W'(r_latency));

        wdata.tag   = r_rdata.tag;
        wdata.dirty = dirty_eff;
        wdata.rank  = rank_new;
        if (hit_now) begin
            if (is_store) begin
                wdata.dirty[hit_way] = 1'b1;
            end
        end else begin
            wdata.tag[victim]   = r_cur.tag;
            wdata.dirty[victim] = is_store;
        end

        if (!is_mem) begin
            cost_now = r_cur.base_cycles;
        end else if (hit_now) begin
            cost_now = 32'd2;
        end else begin
            cost_now = 32'd1 + 32'(idle_now);
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rdata <= r_mem[i_item.set_idx];
            r_cur   <= i_item;
        end
        if (commit && is_mem) begin
            r_mem[r_cur.set_idx] <= wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_hit    <= is_mem && hit_now;
            r_wb     <= is_mem && wb_now;
            r_access <= cost_now;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= BK_IDLE;
            r_latency      <= LAT_RESET;
            r_valid        <= '{default: '0};
            r_out_valid    <= 1'b0;
            r_cycle_count  <= '0;
            r_idle_count   <= '0;
            r_loads        <= '0;
            r_stores       <= '0;
            r_load_misses  <= '0;
            r_store_misses <= '0;
            r_computes     <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                r_latency <= i_cfg_wr_data;
            end
            if (commit) begin
                r_out_valid   <= 1'b1;
                r_cycle_count <= r_cycle_count + cost_now;
                if (is_mem) begin
                    r_valid[r_cur.set_idx][target] <= 1'b1;
                    if (!hit_now) begin
                        r_idle_count <= r_idle_count + 32'(idle_now);
                    end
                end
                case (r_cur.op)
                    OP_LOAD: begin
                        r_loads <= r_loads + 32'd1;
                        if (!hit_now) begin
                            r_load_misses <= r_load_misses + 32'd1;
                        end
                    end
                    OP_STORE: begin
                        r_stores <= r_stores + 32'd1;
                        if (!hit_now) begin
                            r_store_misses <= r_store_misses + 32'd1;
                        end
                    end
                    OP_COMPUTE: begin
                        r_computes <= r_computes + 32'd1;
                    end
                    default: begin
                    end
                endcase
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_hit              = r_hit;
    assign o_writeback        = r_wb;
    assign o_access_cycles    = r_access;
    assign o_total_cycles     = r_cycle_count;
    assign o_idle_total       = r_idle_count;
    assign o_load_total       = r_loads;
    assign o_store_total      = r_stores;
    assign o_load_miss_total  = r_load_misses;
    assign o_store_miss_total = r_store_misses;
    assign o_compute_total    = r_computes;

endmodule
`default_nettype wire

FILE: rtl/core/lru_set_assoc_cache_timing_unit.sv
// Timing model of a 16-set, 4-way write-back cache with true LRU replacement and
// 64-byte lines. Items enter a two-entry queue; the back end then takes one item
// at a time, as it reads the set's tag, dirty and recency row from a single-port
// row memory when it pops the item and writes the updated row back when it
// commits, which a stalled output can delay. Results wait in an output register,
// while the queue keeps taking items until full. Valid bits live in flip-flops, so
// no clearing pass is needed after reset. Write memory_latency only while idle.
`timescale 1ns / 1ps
`default_nettype none
module lru_set_assoc_cache_timing_unit import lruc_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_wr_en,
    input  wire logic [LAT_W-1:0] i_cfg_wr_data,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire logic [1:0]       i_operation,
    input  wire logic [31:0]      i_address,
    input  wire logic [31:0]      i_delay_cycles,
    input  wire logic             i_peer_supplies,
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    output logic                  o_hit,
    output logic                  o_writeback,
    output logic [31:0]           o_access_cycles,
    output logic [31:0]           o_total_cycles,
    output logic [31:0]           o_idle_total,
    output logic [31:0]           o_load_total,
    output logic [31:0]           o_store_total,
    output logic [31:0]           o_load_miss_total,
    output logic [31:0]           o_store_miss_total,
    output logic [31:0]           o_compute_total
);

    t_item item;
    logic  item_valid;
    logic  item_pop;

    lruc_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_operation     (i_operation),
        .i_address       (i_address),
        .i_delay_cycles  (i_delay_cycles),
        .i_peer_supplies (i_peer_supplies),
        .o_item          (item),
        .o_item_valid    (item_valid),
        .i_item_pop      (item_pop)
    );

    lruc_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_wr_en        (i_cfg_wr_en),
        .i_cfg_wr_data      (i_cfg_wr_data),
        .i_item             (item),
        .i_item_valid       (item_valid),
        .o_item_pop         (item_pop),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_hit              (o_hit),
        .o_writeback        (o_writeback),
        .o_access_cycles    (o_access_cycles),
        .o_total_cycles     (o_total_cycles),
        .o_idle_total       (o_idle_total),
        .o_load_total       (o_load_total),
        .o_store_total      (o_store_total),
        .o_load_miss_total  (o_load_miss_total),
        .o_store_miss_total (o_store_miss_total),
        .o_compute_total    (o_compute_total)
    );

endmodule
`default_nettype wire

FILE: rtl/core/lruc_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module lruc_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_out_valid,
    input wire logic        i_out_stall,
    input wire logic        o_hit,
    input wire logic        o_writeback,
    input wire logic [31:0] o_access_cycles,
    input wire logic [31:0] o_total_cycles
);

    a_out_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result item dropped while stalled");

    a_hit_cost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_hit |-> o_access_cycles == 32'd2)
        else $error("hit item does not cost two cycles");

    a_wb_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_writeback |-> !o_hit)
        else $error("writeback reported on a hit");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_total_cycles == 32'd0)
        else $error("reset did not clear the result and cycle count");

endmodule

bind lru_set_assoc_cache_timing_unit lruc_checker u_lruc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_hit           (o_hit),
    .o_writeback     (o_writeback),
    .o_access_cycles (o_access_cycles),
    .o_total_cycles  (o_total_cycles)
);
`default_nettype wire
